// File: rtl/lat_pkg.sv
`timescale 1ns / 1ps
package lat_pkg;

    localparam int TAGS = 1024;
    localparam int BINS = 32;

    localparam int TAG_W  = 10;
    localparam int TIME_W = 64;
    localparam int SEL_W  = 5;
    localparam int BKT_W  = 5;
    localparam int CNT_W  = 64;
    localparam int KIND_W = 2;

    localparam int TW     = $clog2(TAGS);
    localparam int HB     = $clog2(BINS);
    localparam int CLR_N  = (TAGS > BINS) ? TAGS : BINS;
    localparam int CLRW   = $clog2(CLR_N);

    localparam int IN_DATA_W  = ((TAG_W + TIME_W + SEL_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + BKT_W + CNT_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int THR_W  = TIME_W + 11;
    localparam logic [THR_W-1:0] US_DIV = THR_W'(1000);

    localparam logic [KIND_W-1:0] REQ_ENTER = 2'd0;
    localparam logic [KIND_W-1:0] REQ_EXIT  = 2'd1;
    localparam logic [KIND_W-1:0] REQ_READ  = 2'd2;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_READ = 6'b000100,
        S_BIN  = 6'b001000,
        S_UPD  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    // tag reduced modulo the table depth
    function automatic logic [TW-1:0] tag_slot(input logic [TAG_W-1:0] t);
        logic [TAG_W-1:0] base;
        base = '0;
        for (int k = 1; k <= 1023 / TAGS; k++) begin
            if (t >= TAG_W'(k * TAGS)) begin
                base = TAG_W'(k * TAGS);
            end
        end
        return TW'(t - base);
    endfunction

    // floor log2 of delta / 1000 (zero raised to one), clamped to the last bin
    function automatic logic [HB-1:0] bucket_of(input logic [TIME_W-1:0] d);
        logic [THR_W-1:0] dx;
        logic [HB-1:0]    b;
        dx = THR_W'(d);
        b  = '0;
        for (int k = 1; k < BINS; k++) begin
            if (dx >= (US_DIV << k)) begin
                b = HB'(k);
            end
        end
        return b;
    endfunction

endpackage

// File: rtl/lat_ram.sv
`timescale 1ns / 1ps
module lat_ram #(
    parameter int W = 64,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/latency_log2_histogram.sv
`timescale 1ns / 1ps
// enter and read requests go from idle to output; exits pass through read, bin and update
// one item at a time; a result held by m_axis_tready keeps the next request waiting
// the steps follow the registered read and write-back of the tag and histogram memories
// reset: the valid table and histogram are swept one entry a cycle with s_axis_tready low;
// the total clears at once
module latency_log2_histogram (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tag, time_ns, bin_select, zero pad
    input  logic [lat_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [lat_pkg::KIND_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // matched, bucket, bin_count, total_count, zero pad
    output logic [lat_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import lat_pkg::*;

    t_state r_state, n_state;

    logic [CLRW-1:0]   r_clr;
    logic [KIND_W-1:0] r_kind;
    logic [TW-1:0]     r_slot;
    logic [TIME_W-1:0] r_time;
    logic [SEL_W-1:0]  r_sel;
    logic              r_hit;
    logic [TIME_W-1:0] r_delta;
    logic [HB-1:0]     r_bucket;
    logic [CNT_W-1:0]  r_total;
    logic              r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic [TAG_W-1:0]  in_tag;
    logic [TIME_W-1:0] in_time;
    logic [SEL_W-1:0]  in_sel;
    logic              accept;
    logic              out_free;

    logic [TW-1:0]     tag_addr;
    logic              st_we, vld_we, vld_wdata;
    logic [TIME_W-1:0] st_rdata;
    logic              vld_rdata;
    logic [HB-1:0]     hist_addr;
    logic              hist_we;
    logic [CNT_W-1:0]  hist_wdata, hist_rdata;
    logic [HB-1:0]     bkt_next;
    logic              sel_ok, matched;
    logic [BKT_W-1:0]  bkt_out;
    logic [CNT_W-1:0]  bin_out;

    assign in_tag  = s_axis_tdata[TAG_W-1:0];
    assign in_time = s_axis_tdata[TAG_W+TIME_W-1:TAG_W];
    assign in_sel  = s_axis_tdata[TAG_W+TIME_W+SEL_W-1:TAG_W+TIME_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign bkt_next      = bucket_of(r_delta);

    always_comb begin
        tag_addr  = r_slot;
        st_we     = 1'b0;
        vld_we    = 1'b0;
        vld_wdata = 1'b0;
        hist_addr = HB'({2'b00, r_sel});
        hist_we   = 1'b0;
        hist_wdata = hist_rdata + CNT_W'(1);
        case (r_state)
            S_CLR: begin
                tag_addr   = r_clr[TW-1:0];
                vld_we     = 1'b1;
                hist_addr  = r_clr[HB-1:0];
                hist_we    = (CLRW'(r_clr) < CLRW'(BINS)) || (CLR_N == BINS);
                hist_wdata = '0;
            end
            S_IDLE: begin
                tag_addr  = tag_slot(in_tag);
                hist_addr = HB'({2'b00, in_sel});
                if (accept && s_axis_tuser == REQ_ENTER) begin
                    st_we     = 1'b1;
                    vld_we    = 1'b1;
                    vld_wdata = 1'b1;
                end
            end
            S_BIN: begin
                hist_addr = bkt_next;
                vld_we    = r_hit;
            end
            S_UPD: begin
                hist_addr = r_bucket;
                hist_we   = r_hit;
            end
            default: begin
            end
        endcase
    end

    lat_ram #(.W(TIME_W), .D(TAGS)) u_start_ram (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_addr (tag_addr),
        .i_wdata(in_time),
        .o_rdata(st_rdata)
    );

    lat_ram #(.W(1), .D(TAGS)) u_valid_ram (
        .i_clk  (i_clk),
        .i_we   (vld_we),
        .i_addr (tag_addr),
        .i_wdata(vld_wdata),
        .o_rdata(vld_rdata)
    );

    lat_ram #(.W(CNT_W), .D(BINS)) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (hist_we),
        .i_addr (hist_addr),
        .i_wdata(hist_wdata),
        .o_rdata(hist_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr == CLRW'(CLR_N - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    n_state = (s_axis_tuser == REQ_EXIT) ? S_READ : S_OUT;
                end
            end
            S_READ: n_state = S_BIN;
            S_BIN:  n_state = S_UPD;
            S_UPD:  n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    assign matched = (r_kind == REQ_EXIT) && r_hit;
    assign bkt_out = matched ? BKT_W'(r_bucket) : '0;
    assign sel_ok  = ({2'b00, r_sel} < 7'(BINS));
    assign bin_out = ((r_kind == REQ_READ) && sel_ok) ? hist_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + CLRW'(1);
            end
            if (r_state == S_UPD && r_hit) begin
                r_total <= r_total + CNT_W'(1);
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= s_axis_tuser;
            r_slot <= tag_slot(in_tag);
            r_time <= in_time;
            r_sel  <= in_sel;
        end
        if (r_state == S_READ) begin
            r_hit   <= vld_rdata;
            r_delta <= r_time - st_rdata;
        end
        if (r_state == S_BIN) begin
            r_bucket <= bkt_next;
        end
        if (r_state == S_OUT && out_free) begin
            r_odata <= OUT_DATA_W'({r_total, bin_out, bkt_out, matched});
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // total moves only on the update of a matched exit
    a_total_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_UPD) |=> (r_total == $past(r_total)))
        else $error("total changed outside update");

    // a new result is loaded only from the output state
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside output state");

    // no transaction is taken while the tables are being cleared
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !s_axis_tready)
        else $error("input ready during clearing pass");

    // histogram is written only while clearing or on a matched exit update
    a_hist_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_we |-> (r_state == S_CLR || (r_state == S_UPD && r_hit)))
        else $error("unexpected histogram write");

endmodule
